[src/ahp_pkg.sv]
// Shared types and constants of the audio header parser.
`default_nettype none

package ahp_pkg;

    // parse phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_MAGIC = 4'd1;
    localparam logic [3:0] PH_WAV   = 4'd2;
    localparam logic [3:0] PH_AU    = 4'd3;
    localparam logic [3:0] PH_SKIP  = 4'd4;
    localparam logic [3:0] PH_DATA  = 4'd5;
    localparam logic [3:0] PH_HALT  = 4'd6;

    // result kinds
    localparam logic [1:0] KIND_DESC = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_MAGIC    = 4'd1;
    localparam logic [3:0] ST_NOT_WAVE = 4'd2;
    localparam logic [3:0] ST_NO_FMT   = 4'd3;
    localparam logic [3:0] ST_ENCODING = 4'd4;
    localparam logic [3:0] ST_BITS     = 4'd5;
    localparam logic [3:0] ST_INCONS   = 4'd6;
    localparam logic [3:0] ST_NO_DATA  = 4'd7;
    localparam logic [3:0] ST_SHORT_AU = 4'd8;

    // sample formats
    localparam logic [1:0] FMT_U8    = 2'd0;
    localparam logic [1:0] FMT_S16LE = 2'd1;
    localparam logic [1:0] FMT_S8    = 2'd2;
    localparam logic [1:0] FMT_S16BE = 2'd3;

    // container magic words, big-endian as they arrive
    localparam logic [31:0] MAGIC_RIFF = 32'h52494646;
    localparam logic [31:0] MAGIC_AU   = 32'h2e736e64;
    localparam logic [31:0] MAGIC_WAVE = 32'h57415645;
    localparam logic [31:0] MAGIC_FMT  = 32'h666d7420;
    localparam logic [31:0] MAGIC_DATA = 32'h64617461;

    localparam logic [31:0] AU_MIN_OFFSET = 32'd24;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  status;
        logic [1:0]  sample_format;
        logic [31:0] channel_count;
        logic [31:0] rate_hz;
        logic [4:0]  sample_bits;
        logic [31:0] payload_bytes;
        logic [7:0]  sample_byte;
    } res_t;

endpackage

`default_nettype wire

[src/ahp_in_if.sv]
// Input channel of the audio header parser: one file byte per beat.
`default_nettype none

interface ahp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

[src/ahp_out_if.sv]
// Result channel of the audio header parser: one descriptor, data byte or error per beat.
`default_nettype none

interface ahp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [3:0]  status;
    logic [1:0]  sample_format;
    logic [31:0] channel_count;
    logic [31:0] rate_hz;
    logic [4:0]  sample_bits;
    logic [31:0] payload_bytes;
    logic [7:0]  sample_byte;

    modport source (output valid, output result_kind, output status, output sample_format,
                    output channel_count, output rate_hz, output sample_bits,
                    output payload_bytes, output sample_byte, input ready);
    modport sink   (input valid, input result_kind, input status, input sample_format,
                    input channel_count, input rate_hz, input sample_bits,
                    input payload_bytes, input sample_byte, output ready);
endinterface

`default_nettype wire

[src/ahp_parser.sv]
// Header parse state and per-byte decode logic.
`default_nettype none

module ahp_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   file_byte,
    input  wire logic         start_of_file,
    output ahp_pkg::res_t     res,
    output logic              res_valid
);

    logic [3:0]  phase_reg,  phase_next;
    logic [31:0] pos_reg,    pos_next;
    logic [31:0] ws_reg,     ws_next;
    logic [31:0] ch_reg,     ch_next;
    logic [31:0] rate_reg,   rate_next;
    logic [31:0] brate_reg,  brate_next;
    logic [15:0] balign_reg, balign_next;
    logic [4:0]  bits_reg,   bits_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] size_reg,   size_next;
    logic [1:0]  fmt_reg,    fmt_next;
    logic [47:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ahp_pkg::PH_IDLE;
            pos_reg    <= '0;
            ws_reg     <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            brate_reg  <= '0;
            balign_reg <= '0;
            bits_reg   <= '0;
            offset_reg <= '0;
            size_reg   <= '0;
            fmt_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            ws_reg     <= ws_next;
            ch_reg     <= ch_next;
            rate_reg   <= rate_next;
            brate_reg  <= brate_next;
            balign_reg <= balign_next;
            bits_reg   <= bits_next;
            offset_reg <= offset_next;
            size_reg   <= size_next;
            fmt_reg    <= fmt_next;
        end
    end

    // block align * rate, ready well before bits per sample arrives two bytes later
    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, balign_reg} * {16'd0, rate_reg};
    end

    logic [31:0] ws_new;
    logic [15:0] sw16;
    logic [31:0] sw32;
    logic [32:0] exp_align;
    logic        emit_desc;
    logic        emit_data;
    logic        emit_err;
    logic [3:0]  err_code;

    always_comb
    begin
        // a start byte sees a cleared parse context
        phase_next  = start_of_file ? ahp_pkg::PH_MAGIC : phase_reg;
        pos_next    = start_of_file ? '0 : pos_reg;
        ws_next     = start_of_file ? '0 : ws_reg;
        ch_next     = start_of_file ? '0 : ch_reg;
        rate_next   = start_of_file ? '0 : rate_reg;
        brate_next  = start_of_file ? '0 : brate_reg;
        balign_next = start_of_file ? '0 : balign_reg;
        bits_next   = start_of_file ? '0 : bits_reg;
        offset_next = start_of_file ? '0 : offset_reg;
        size_next   = start_of_file ? '0 : size_reg;
        fmt_next    = start_of_file ? '0 : fmt_reg;

        ws_new    = {ws_next[23:0], file_byte};
        sw16      = {ws_new[7:0], ws_new[15:8]};
        sw32      = {ws_new[7:0], ws_new[15:8], ws_new[23:16], ws_new[31:24]};
        exp_align = (sw16 == 16'd16) ? {ch_next, 1'b0} : {1'b0, ch_next};

        emit_desc = 1'b0;
        emit_data = 1'b0;
        emit_err  = 1'b0;
        err_code  = ahp_pkg::ST_OK;

        case (phase_next)
            ahp_pkg::PH_DATA:
            begin
                emit_data = 1'b1;
            end
            ahp_pkg::PH_SKIP:
            begin
                if (pos_next == offset_next)
                begin
                    phase_next = ahp_pkg::PH_DATA;
                    emit_data  = 1'b1;
                end
                else
                begin
                    pos_next = pos_next + 32'd1;
                end
            end
            ahp_pkg::PH_MAGIC:
            begin
                if (pos_next == 32'd3)
                begin
                    if (ws_new == ahp_pkg::MAGIC_RIFF)
                        phase_next = ahp_pkg::PH_WAV;
                    else if (ws_new == ahp_pkg::MAGIC_AU)
                        phase_next = ahp_pkg::PH_AU;
                    else
                    begin
                        emit_err = 1'b1;
                        err_code = ahp_pkg::ST_MAGIC;
                    end
                end
            end
            ahp_pkg::PH_WAV:
            begin
                case (pos_next)
                    32'd11:
                        if (ws_new != ahp_pkg::MAGIC_WAVE)
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_NOT_WAVE;
                        end
                    32'd15:
                        if (ws_new != ahp_pkg::MAGIC_FMT)
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_NO_FMT;
                        end
                    32'd21:
                        if (sw16 != 16'd1)
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_ENCODING;
                        end
                    32'd23: ch_next     = {16'd0, sw16};
                    32'd27: rate_next   = sw32;
                    32'd31: brate_next  = sw32;
                    32'd33: balign_next = sw16;
                    32'd35:
                    begin
                        if (sw16 == 16'd8 || sw16 == 16'd16)
                        begin
                            bits_next = sw16[4:0];
                            fmt_next  = (sw16 == 16'd8) ? ahp_pkg::FMT_U8
                                                        : ahp_pkg::FMT_S16LE;
                            if (({17'd0, balign_next} != exp_align) ||
                                (prod_reg != {16'd0, brate_next}))
                            begin
                                emit_err = 1'b1;
                                err_code = ahp_pkg::ST_INCONS;
                            end
                        end
                        else
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_BITS;
                        end
                    end
                    32'd39:
                        if (ws_new != ahp_pkg::MAGIC_DATA)
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_NO_DATA;
                        end
                    32'd43:
                    begin
                        size_next  = sw32;
                        phase_next = ahp_pkg::PH_DATA;
                        emit_desc  = 1'b1;
                    end
                    default: ;
                endcase
            end
            ahp_pkg::PH_AU:
            begin
                case (pos_next)
                    32'd7:  offset_next = ws_new;
                    32'd11: size_next   = ws_new;
                    32'd15:
                        if (ws_new == 32'd2)
                        begin
                            bits_next = 5'd8;
                            fmt_next  = ahp_pkg::FMT_S8;
                        end
                        else if (ws_new == 32'd3)
                        begin
                            bits_next = 5'd16;
                            fmt_next  = ahp_pkg::FMT_S16BE;
                        end
                        else
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_ENCODING;
                        end
                    32'd19: rate_next = ws_new;
                    32'd23:
                    begin
                        ch_next = ws_new;
                        if (offset_next < ahp_pkg::AU_MIN_OFFSET)
                        begin
                            emit_err = 1'b1;
                            err_code = ahp_pkg::ST_SHORT_AU;
                        end
                        else
                        begin
                            phase_next = (offset_next == ahp_pkg::AU_MIN_OFFSET)
                                       ? ahp_pkg::PH_DATA : ahp_pkg::PH_SKIP;
                            emit_desc  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // header phases shift the byte in and advance the position
        if (phase_next == ahp_pkg::PH_MAGIC || phase_next == ahp_pkg::PH_WAV ||
            phase_next == ahp_pkg::PH_AU ||
            ((phase_reg == ahp_pkg::PH_MAGIC || phase_reg == ahp_pkg::PH_WAV ||
              phase_reg == ahp_pkg::PH_AU || start_of_file) && !emit_data))
        begin
            if (start_of_file || phase_reg == ahp_pkg::PH_MAGIC ||
                phase_reg == ahp_pkg::PH_WAV || phase_reg == ahp_pkg::PH_AU)
            begin
                ws_next  = ws_new;
                pos_next = pos_next + 32'd1;
            end
        end

        if (emit_err)
            phase_next = ahp_pkg::PH_HALT;

        res = '0;
        if (emit_desc)
        begin
            res.result_kind   = ahp_pkg::KIND_DESC;
            res.sample_format = fmt_next;
            res.channel_count = ch_next;
            res.rate_hz       = rate_next;
            res.sample_bits   = bits_next;
            res.payload_bytes = size_next;
        end
        else if (emit_data)
        begin
            res.result_kind = ahp_pkg::KIND_DATA;
            res.sample_byte = file_byte;
        end
        else if (emit_err)
        begin
            res.result_kind = ahp_pkg::KIND_ERR;
            res.status      = err_code;
        end

        res_valid = accept && (emit_desc || emit_data || emit_err);
    end

`ifndef ASSERT_OFF
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == ahp_pkg::KIND_ERR |-> res.status != ahp_pkg::ST_OK)
        else $error("error result with ok status");

    a_desc_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == ahp_pkg::KIND_DESC
        |-> (res.sample_bits == 5'd8 || res.sample_bits == 5'd16))
        else $error("descriptor with bad sample width");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == ahp_pkg::KIND_ERR |=> phase_reg == ahp_pkg::PH_HALT)
        else $error("parse did not halt after error");

    a_desc_enters_body: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == ahp_pkg::KIND_DESC
        |=> (phase_reg == ahp_pkg::PH_DATA || phase_reg == ahp_pkg::PH_SKIP))
        else $error("descriptor without entering the data body");
`endif

endmodule

`default_nettype wire

[src/ahp_out_reg.sv]
// Result register between the parser and the result channel.
`default_nettype none

module ahp_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire ahp_pkg::res_t  res,
    input  wire logic           res_valid,
    output logic                room,
    ahp_out_if.source           result_ch
);

    logic          valid_reg, valid_next;
    ahp_pkg::res_t data_reg;

    // room for a new beat when empty or the current one leaves this cycle
    assign room = !valid_reg || result_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = res_valid;
        else if (result_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            data_reg <= res;
    end

    assign result_ch.valid         = valid_reg;
    assign result_ch.result_kind   = data_reg.result_kind;
    assign result_ch.status        = data_reg.status;
    assign result_ch.sample_format = data_reg.sample_format;
    assign result_ch.channel_count = data_reg.channel_count;
    assign result_ch.rate_hz       = data_reg.rate_hz;
    assign result_ch.sample_bits   = data_reg.sample_bits;
    assign result_ch.payload_bytes = data_reg.payload_bytes;
    assign result_ch.sample_byte   = data_reg.sample_byte;

endmodule

`default_nettype wire

[src/audio_header_parser.sv]
// Top level of the audio header parser: WAV / AU header decode and data pass-through.
//
// Usage:
//   file_ch   (sink)   one file byte per beat; start_of_file marks byte 0 of a new
//                      file and restarts the parse from any phase.
//   result_ch (source) at most one result beat per input beat: a header descriptor,
//                      a passed-through data byte, or an error code.
//   Bytes 0-3 pick RIFF/WAVE (fixed 44-byte header) or big-endian AU (24-byte
//   header, then skip to the data offset). After an error the block drops bytes
//   until the next start_of_file; before the first start it drops them too.
// Output: each result is registered and appears on result_ch in the cycle after the byte that causes it.
// Throughput: one byte per cycle while result_ch.ready stays high; the decode of
//   each byte fits in the single stage between parse state and result registers.
// Stall: file_ch.ready falls only while a result is held and result_ch.ready is
//   low; bytes that give no result still need that room, so the stream pauses
//   with the receiver.
// Reset: rst_n (async, active low) clears the parse state to idle and empties
//   the result register.
`default_nettype none

module audio_header_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ahp_in_if.sink      file_ch,
    ahp_out_if.source   result_ch
);

    logic          room;
    logic          accept;
    ahp_pkg::res_t res;
    logic          res_valid;

    // a byte is taken whenever the result register can take its result
    assign file_ch.ready = room;
    assign accept        = file_ch.valid && room;

    ahp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .file_byte     (file_ch.file_byte),
        .start_of_file (file_ch.start_of_file),
        .res           (res),
        .res_valid     (res_valid)
    );

    ahp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .res_valid (res_valid),
        .room      (room),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire
